>>> rtl/core/smic_pkg.sv
// ----------------------------------------------------------------------------
// smic_pkg
// Shared types for the sorted multiset store: operation codes and the token
// that travels along the row of cells.
// ----------------------------------------------------------------------------
package smic_pkg;

  // Operation carried by an input beat
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_COUNT  = 1'b1
  } op_e_t;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned OUT_W = 7;

  // Token moving one cell per cycle while the row is not stalled
  typedef struct packed {
    logic                     vld;   // token present
    op_e_t                    op;
    logic                     busy;  // insert still carrying a value to place
    logic                     drop;  // insert refused, store full
    logic signed [VAL_W-1:0]  val;   // value in flight (displaced entry for insert)
    logic [OUT_W-1:0]         cnt;   // running match count, wraps modulo 128
  } tok_t;

endpackage

>>> rtl/core/sorted_multiset_insert_count_top.sv
// ----------------------------------------------------------------------------
// sorted_multiset_insert_count_top
// Bounded multiset of signed 32-bit values kept in ascending order, with
// insert and count-occurrences operations.
// ----------------------------------------------------------------------------
// The store is a row of CAPACITY cells, one entry each. Every accepted beat
// becomes a token that moves one cell per cycle: an insert swaps itself into
// place and pushes larger entries along, a count adds up equal entries. A new
// beat may be accepted every cycle the output does not stall; its token is
// registered in each cell in turn until it leaves the last. A stalled output
// holds the whole row. An insert into a full store returns dropped_full.
module sorted_multiset_insert_count_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_match_count,
  output logic               out_dropped_full,
  output logic [6:0]         out_occupancy
);

  localparam int unsigned TW = $clog2(CAPACITY + 1);
  localparam logic [TW-1:0] CAP = TW'(CAPACITY);

  smic_pkg::tok_t  tok_w [CAPACITY+1];
  logic [TW-1:0]   tot_w [CAPACITY+1];
  logic [TW-1:0]   tot_r;
  logic [TW-1:0]   tot_nxt;
  logic [TW-1:0]   occ_full;
  logic            adv;
  logic            in_acc;
  logic            is_ins;
  logic            full;
  smic_pkg::tok_t  tok_in;
  smic_pkg::tok_t  last;

  // row moves whenever the last stage is empty or being taken
  assign adv      = out_ready || !tok_w[CAPACITY].vld;
  assign in_ready = adv;
  assign in_acc   = in_valid && in_ready;
  assign is_ins   = (smic_pkg::op_e_t'(in_operation) == smic_pkg::OP_INSERT);
  assign full     = (tot_r == CAP);

  // token entering the first cell
  always_comb begin
    tok_in.vld  = in_valid;
    tok_in.op   = smic_pkg::op_e_t'(in_operation);
    tok_in.busy = is_ins && !full;
    tok_in.drop = is_ins && full;
    tok_in.val  = in_value;
    tok_in.cnt  = '0;
  end

  assign tok_w[0] = tok_in;
  assign tot_w[0] = tot_r;

  // entry count as seen by newly accepted beats
  always_comb begin
    tot_nxt = tot_r;
    if (in_acc && is_ins && !full) begin
      tot_nxt = tot_r + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= '0;
    end else begin
      tot_r <= tot_nxt;
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    smic_cell #(
      .INDEX (i),
      .TW    (TW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok_w[i]),
      .tot_i (tot_w[i]),
      .tok_o (tok_w[i+1]),
      .tot_o (tot_w[i+1])
    );
  end

  // result beat from the last cell
  assign last     = tok_w[CAPACITY];
  assign occ_full = tot_w[CAPACITY]
                  + TW'((last.op == smic_pkg::OP_INSERT) && !last.drop);

  assign out_valid        = last.vld;
  assign out_match_count  = last.cnt;
  assign out_dropped_full = last.drop;
  assign out_occupancy    = 7'(occ_full);

  // checks
  a_tot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tot_r <= CAP)
    else $error("entry count beyond capacity");

  a_tot_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (tot_r != $past(tot_r))) |-> (tot_r == $past(tot_r) + TW'(1)))
    else $error("entry count moved by more than one");

  a_drop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped_full) |->
      ((out_occupancy == 7'(CAPACITY)) && (out_match_count == '0)))
    else $error("refused insert with wrong result fields");

  a_ins_placed: assert property (@(posedge clk) disable iff (!rst_n)
    (last.vld && (last.op == smic_pkg::OP_INSERT)) |-> !last.busy)
    else $error("insert left the row without being placed");

endmodule

>>> rtl/core/smic_cell.sv
// ----------------------------------------------------------------------------
// smic_cell
// One slot of the sorted row: holds one entry, compares it with the passing
// token, swaps on insert and counts matches on count.
// ----------------------------------------------------------------------------
module smic_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned TW    = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  smic_pkg::tok_t  tok_i,
  input  logic [TW-1:0]   tot_i,
  output smic_pkg::tok_t  tok_o,
  output logic [TW-1:0]   tot_o
);

  localparam logic [TW-1:0] IDX = TW'(INDEX);

  logic signed [smic_pkg::VAL_W-1:0] entry_r;
  logic signed [smic_pkg::VAL_W-1:0] entry_nxt;
  smic_pkg::tok_t                    tok_r;
  smic_pkg::tok_t                    tok_nxt;
  logic [TW-1:0]                     tot_r;
  logic                              occ;
  logic                              here;

  // slot holds a live entry for this token, or is the first free slot
  assign occ  = (tot_i > IDX);
  assign here = (tot_i == IDX);

  // compare and swap / count
  always_comb begin
    tok_nxt   = tok_i;
    entry_nxt = entry_r;
    if (tok_i.vld) begin
      if (tok_i.op == smic_pkg::OP_COUNT) begin
        if (occ && (entry_r == tok_i.val)) begin
          tok_nxt.cnt = tok_i.cnt + smic_pkg::OUT_W'(1);
        end
      end else if (tok_i.busy) begin
        if (occ) begin
          // strictly larger entry moves on; equal entries stay in front
          if ($signed(entry_r) > $signed(tok_i.val)) begin
            entry_nxt   = tok_i.val;
            tok_nxt.val = entry_r;
          end
        end else if (here) begin
          entry_nxt    = tok_i.val;
          tok_nxt.busy = 1'b0;
        end
      end
    end
  end

  // state and token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      entry_r <= entry_nxt;
      tok_r   <= tok_nxt;
      tot_r   <= tot_i;
    end
  end

  assign tok_o = tok_r;
  assign tot_o = tot_r;

endmodule
